>>> sv/ecs_pkg.sv
// Package: register indexes and sine polynomial constants for the envelope curve sampler.
package ecs_pkg;

  localparam int unsigned ONE_Q16 = 65536;

  localparam logic [2:0] REG_LEVEL_START      = 3'd0;
  localparam logic [2:0] REG_LEVEL_FIRST_KEY  = 3'd1;
  localparam logic [2:0] REG_LEVEL_SECOND_KEY = 3'd2;
  localparam logic [2:0] REG_LEVEL_END        = 3'd3;
  localparam logic [2:0] REG_FIRST_KEY_POS    = 3'd4;
  localparam logic [2:0] REG_SECOND_KEY_POS   = 3'd5;
  localparam logic [2:0] REG_MOD_FREQUENCY    = 3'd6;
  localparam logic [2:0] REG_MOD_AMPLITUDE    = 3'd7;

  localparam longint unsigned SIN_C1 = 64'd1686629713;
  localparam longint unsigned SIN_C3 = 64'd693598670;
  localparam longint unsigned SIN_C5 = 64'd85569306;
  localparam longint unsigned SIN_C7 = 64'd5026995;
  localparam longint unsigned SIN_C9 = 64'd172272;

  function automatic longint unsigned q30mul(longint unsigned a, longint unsigned b);
    longint unsigned p;
    p = a * b;
    return p >> 30;
  endfunction

endpackage

>>> sv/envelope_curve_sampler.sv
// Envelope curve sampler: clamped time in, piecewise-linear envelope plus sine modulation out.
//
// Input channel: time_in_i with in_valid_i / in_stall_o. Output channel:
// curve_value_o with out_valid_o / out_stall_i. An item moves when valid is
// high and stall is low at a rising clk_i edge.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i; write
// only while no item is in flight.
// Throughput: one item per cycle unless out_stall_i holds a waiting result. Path to
// out_valid_o: the accepting edge loads segment select, then 17 restoring
// divider stages form the interpolation fraction, one stage does the lerp
// multiply and the output register takes the final add and saturation.
// The sine ROM is read in parallel with the divider in a registered stage.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the
// register reset values; the ROM is a constant table and needs no fill.
// When out_stall_i holds a waiting result, the whole pipeline freezes and
// in_stall_o rises; nothing is lost or repeated. Bubbles travel as cleared
// valid bits.
module envelope_curve_sampler #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter bit          USE_COSINE       = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [17:0] time_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] curve_value_o
);
  import ecs_pkg::*;

  localparam int unsigned D      = SINE_TABLE_DEPTH;
  localparam int unsigned FOUR_D = 4 * SINE_TABLE_DEPTH;
  localparam int IW = $clog2(FOUR_D);
  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = 24 + IW;
  localparam int DIV_STAGES = 17;
  localparam int NS = DIV_STAGES + 2;

  typedef logic [16:0] rom_t [SINE_TABLE_DEPTH+1];

  function automatic rom_t gen_rom();
    rom_t r;
    longint unsigned x, x2, x3, x5, x7, x9;
    longint s;
    for (int k = 0; k <= int'(SINE_TABLE_DEPTH); k++) begin
      x  = (longint'(k) << 30) / SINE_TABLE_DEPTH;
      x2 = q30mul(x, x);
      x3 = q30mul(x2, x);
      x5 = q30mul(x3, x2);
      x7 = q30mul(x5, x2);
      x9 = q30mul(x7, x2);
      s = longint'(q30mul(SIN_C1, x)) - longint'(q30mul(SIN_C3, x3))
        + longint'(q30mul(SIN_C5, x5)) - longint'(q30mul(SIN_C7, x7))
        + longint'(q30mul(SIN_C9, x9));
      if (s < 0) s = 0;
      s = (s + 8192) >>> 14;
      if (s > longint'(ONE_Q16)) s = longint'(ONE_Q16);
      r[k] = s[16:0];
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = gen_rom();

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic [16:0]        den;
    logic [32:0]        rem;
    logic [16:0]        quo;
    logic               zden;
    logic [16:0]        tu;
    logic [23:0]        phase;
    logic [IW-1:0]      idx;
    logic [AW-1:0]      addr;
    logic               neg;
    logic signed [17:0] modv;
    logic signed [34:0] prod;
  } stg_t;

  logic signed [15:0] lvl_q [4];
  logic [16:0] key0_q, key1_q;
  logic [15:0] freq_q;
  logic signed [15:0] amp_q;

  logic [NS-1:0] v_q;
  stg_t p_q [NS];
  stg_t p_d [NS];
  stg_t s0_d;
  logic [16:0] sin_q;
  logic out_valid_q;
  logic signed [15:0] out_q, out_d;
  logic adv;

  assign adv = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign out_valid_o = out_valid_q;
  assign curve_value_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) lvl_q[i] <= '0;
      key0_q <= 17'd21627;
      key1_q <= 17'd43254;
      freq_q <= '0;
      amp_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEVEL_START:      lvl_q[0] <= cfg_data_i[15:0];
        REG_LEVEL_FIRST_KEY:  lvl_q[1] <= cfg_data_i[15:0];
        REG_LEVEL_SECOND_KEY: lvl_q[2] <= cfg_data_i[15:0];
        REG_LEVEL_END:        lvl_q[3] <= cfg_data_i[15:0];
        REG_FIRST_KEY_POS:    key0_q   <= cfg_data_i;
        REG_SECOND_KEY_POS:   key1_q   <= cfg_data_i;
        REG_MOD_FREQUENCY:    freq_q   <= cfg_data_i[15:0];
        REG_MOD_AMPLITUDE:    amp_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Stage 0: clamp, segment select, divider setup.
  always_comb begin
    logic [16:0] tu, k0, k1, num, den;
    stg_t n;
    n = '0;
    if (time_in_i < 0) tu = '0;
    else if (time_in_i > 18'sd65536) tu = 17'd65536;
    else tu = time_in_i[16:0];
    k0 = (key0_q > 17'd65536) ? 17'd65536 : key0_q;
    k1 = (key1_q > 17'd65536) ? 17'd65536 : key1_q;
    if (tu < k0) begin
      n.a = lvl_q[0]; n.b = lvl_q[1]; num = tu; den = k0;
    end else if (tu < k1) begin
      n.a = lvl_q[1]; n.b = lvl_q[2]; num = tu - k0; den = k1 - k0;
    end else begin
      n.a = lvl_q[2]; n.b = lvl_q[3]; num = tu - k1; den = 17'd65536 - k1;
    end
    n.tu   = tu;
    n.den  = den;
    n.zden = (den == '0);
    n.rem  = {num, 16'd0};
    s0_d = n;
  end

  // Stages 1..18: divider bits, phase, ROM address, modulation, lerp product.
  always_comb begin
    stg_t n;
    logic [33:0] dsh;
    logic [PW-1:0] idxp;
    logic [IW:0] ix;
    logic [IW:0] r;
    logic [1:0] q;
    logic signed [33:0] mprod;
    logic [17:0] frac;
    logic signed [16:0] diff;
    dsh   = '0;
    idxp  = '0;
    ix    = '0;
    r     = '0;
    q     = '0;
    mprod = '0;
    frac  = '0;
    diff  = '0;
    p_d[0] = s0_d;
    for (int k = 1; k < NS; k++) begin
      n = p_q[k-1];
      if (k <= DIV_STAGES) begin
        dsh = 34'(n.den) << (DIV_STAGES - k);
        if ({1'b0, n.rem} >= dsh) begin
          n.rem = n.rem - dsh[32:0];
          n.quo[DIV_STAGES - k] = 1'b1;
        end
      end
      if (k == 1) begin
        n.phase = 24'(34'(n.tu) * 34'(freq_q));
      end
      if (k == 2) begin
        idxp = PW'(n.phase) * PW'(FOUR_D);
        ix = {1'b0, idxp[PW-1:24]};
        if (USE_COSINE) begin
          ix = ix + (IW+1)'(D);
          if (ix >= (IW+1)'(FOUR_D)) ix = ix - (IW+1)'(FOUR_D);
        end
        n.idx = ix[IW-1:0];
      end
      if (k == 3) begin
        ix = {1'b0, n.idx};
        if (ix >= (IW+1)'(3 * D)) begin
          q = 2'd3; r = ix - (IW+1)'(3 * D);
        end else if (ix >= (IW+1)'(2 * D)) begin
          q = 2'd2; r = ix - (IW+1)'(2 * D);
        end else if (ix >= (IW+1)'(D)) begin
          q = 2'd1; r = ix - (IW+1)'(D);
        end else begin
          q = 2'd0; r = ix;
        end
        n.addr = q[0] ? AW'((IW+1)'(D) - r) : AW'(r);
        n.neg  = q[1];
      end
      if (k == 5) begin
        mprod = 34'(amp_q) * $signed({1'b0, sin_q});
        if (p_q[4].neg) mprod = -mprod;
        mprod = mprod + 34'sd32768;
        n.modv = (amp_q > 0) ? 18'(mprod >>> 16) : '0;
      end
      if (k == DIV_STAGES + 1) begin
        frac = (n.zden || n.quo > 17'd65536) ? 18'd65536 : {1'b0, n.quo};
        diff = 17'(n.b) - 17'(n.a);
        n.prod = 35'(diff) * $signed({1'b0, frac});
      end
      p_d[k] = n;
    end
  end

  // Final: lerp round, add modulation, saturate.
  always_comb begin
    logic signed [35:0] rp;
    logic signed [20:0] sum;
    stg_t s;
    s = p_q[NS-1];
    rp = 36'(s.prod) + 36'sd32768;
    sum = 21'(s.a) + 21'(rp >>> 16) + 21'(s.modv);
    if (sum > 21'sd32767) out_d = 16'sh7FFF;
    else if (sum < -21'sd32768) out_d = 16'sh8000;
    else out_d = sum[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
      out_valid_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) p_q[k] <= p_d[k];
      sin_q <= SINE_ROM[p_q[3].addr];
      out_q <= out_d;
    end
  end

endmodule
